// ===== src/rsc_pkg.sv =====
package rsc_pkg;

  // default sizes
  localparam int VALUE_BITS_DEF = 63;
  localparam int MAX_DIGITS_DEF = 64;

  // one stored digit of the destination base
  localparam int DIGIT_W = 6;

  // character codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;

  // digit values
  localparam logic [6:0] DIGIT_TEN  = 7'd10;
  localparam logic [6:0] DIGIT_NONE = 7'd99;

  // base limits
  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] BASE_HEX = 6'd16;

  // register indexes
  typedef enum logic {
    REG_SRC_BASE = 1'b0,
    REG_DST_BASE = 1'b1
  } cfg_reg_t;

  // parse phase of the incoming string
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } parse_phase_t;

  // hex prefix tracking
  typedef enum logic [1:0] {
    HEX_NONE    = 2'd0,
    HEX_ZERO    = 2'd1,
    HEX_AFTER_X = 2'd2
  } hex_prefix_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PREP  = 3'd1,
    ST_CHECK = 3'd2,
    ST_DIV   = 3'd3,
    ST_STORE = 3'd4,
    ST_READ  = 3'd5,
    ST_LOAD  = 3'd6,
    ST_WAIT  = 3'd7
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic parse;     // take the character on the input
    logic prep;      // apply sign, start conversion
    logic div_step;  // one bit of restoring division
    logic store;     // write remainder into the digit store
    logic read;      // fetch the next digit to show
    logic load;      // fill the output register
    logic clear;     // return parse state to reset
  } rsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_zero;
    logic div_done;
    logic count_full;
    logic count_zero;
  } rsc_status_t;

  // value of a digit character, DIGIT_NONE when not a digit
  function automatic logic [6:0] digit_value(input logic [7:0] c);
    logic [6:0] v;
    v = DIGIT_NONE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = 7'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = 7'(c - CHAR_UPPER_A) + DIGIT_TEN;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      v = 7'(c - CHAR_LOWER_A) + DIGIT_TEN;
    end
    return v;
  endfunction

  // space, tab, lf, vt, ff, cr
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // out of range bases act as the nearest limit
  function automatic logic [5:0] clamp_base(input logic [5:0] b);
    logic [5:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

  // digit to ascii 0-9, A-Z
  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] r);
    logic [6:0] ch;
    if (7'(r) < DIGIT_TEN) begin
      ch = 7'(r) + CHAR_ZERO[6:0];
    end else begin
      ch = 7'(r) - DIGIT_TEN + CHAR_UPPER_A[6:0];
    end
    return ch;
  endfunction

endpackage

// ===== src/rsc_ctrl.sv =====
module rsc_ctrl
  import rsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_is_last,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  rsc_status_t status,
  output rsc_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && (state_r == ST_IDLE);
  assign out_xfer = (state_r == ST_WAIT) && !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_is_last) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = status.acc_zero ? ST_STORE : ST_DIV;
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        if (status.acc_zero || status.count_full) state_nxt = ST_READ;
        else state_nxt = ST_DIV;
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (out_xfer) state_nxt = status.count_zero ? ST_IDLE : ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.parse = in_valid;
      end
      ST_PREP:  cmd.prep = 1'b1;
      ST_CHECK: cmd = '0;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_STORE: cmd.store = 1'b1;
      ST_READ:  cmd.read = 1'b1;
      ST_LOAD:  cmd.load = 1'b1;
      ST_WAIT: begin
        out_valid = 1'b1;
        cmd.clear = out_xfer && status.count_zero;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/rsc_dp.sv =====
module rsc_dp
  import rsc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [5:0]  src_base,
  input  logic [5:0]  dst_base,
  input  logic [7:0]  in_char_code,
  input  rsc_cmd_t    cmd,
  output rsc_status_t status,
  output logic [6:0]  out_digit_code,
  output logic        out_last_digit
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int BW = $clog2(VALUE_BITS);
  localparam int PW = VALUE_BITS + DIGIT_W;

  // parse state
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  parse_phase_t          phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  hex_prefix_t           hex_r, hex_nxt;

  // conversion state
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [DIGIT_W-1:0]    rdata_r;
  logic [6:0]            digit_r;
  logic                  last_r;
  logic [DIGIT_W-1:0]    store_mem [MAX_DIGITS];

  logic [6:0]            dval;
  logic                  dvalid;
  logic                  is_sign;
  logic                  is_x;
  logic [PW-1:0]         prod;
  logic [PW:0]           mac;
  logic [VALUE_BITS-1:0] acc_mac;
  logic [DIGIT_W:0]      trial;
  logic                  trial_ge;
  logic [DIGIT_W:0]      trial_sub;
  logic [CW-1:0]         cnt_m1;

  // character classification
  assign dval    = digit_value(in_char_code);
  assign dvalid  = dval < {1'b0, src_base};
  assign is_sign = (in_char_code == CHAR_PLUS) || (in_char_code == CHAR_MINUS);
  assign is_x    = (in_char_code == CHAR_UPPER_X) || (in_char_code == CHAR_LOWER_X);

  // multiply-accumulate with saturation at all ones
  assign prod    = {{DIGIT_W{1'b0}}, acc_r} * {{VALUE_BITS{1'b0}}, src_base};
  assign mac     = {1'b0, prod} + {{(PW + 1 - DIGIT_W){1'b0}}, dval[DIGIT_W-1:0]};
  assign acc_mac = (|mac[PW:VALUE_BITS]) ? '1 : mac[VALUE_BITS-1:0];

  // one restoring division step
  assign trial     = {rem_r, acc_r[VALUE_BITS-1]};
  assign trial_ge  = trial >= {1'b0, dst_base};
  assign trial_sub = trial - {1'b0, dst_base};

  assign cnt_m1 = cnt_r - CW'(1);

  // next state of parse and conversion
  always_comb begin
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    hex_nxt   = hex_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    if (cmd.parse) begin
      if (phase_r == PH_STOP) begin
        phase_nxt = PH_STOP;
      end else if (phase_r == PH_SPACE && is_blank(in_char_code)) begin
        phase_nxt = PH_SPACE;
      end else if (phase_r == PH_SPACE && is_sign) begin
        neg_nxt   = (in_char_code == CHAR_MINUS);
        phase_nxt = PH_SIGN;
      end else if (phase_r == PH_DIGITS && hex_r == HEX_ZERO && is_x) begin
        hex_nxt = HEX_AFTER_X;
      end else if (!dvalid) begin
        phase_nxt = PH_STOP;
      end else begin
        if (phase_r != PH_DIGITS && src_base == BASE_HEX && dval == '0) hex_nxt = HEX_ZERO;
        else hex_nxt = HEX_NONE;
        phase_nxt = PH_DIGITS;
        acc_nxt   = acc_mac;
      end
    end else if (cmd.prep) begin
      if (neg_r) acc_nxt = '0;
      cnt_nxt = '0;
      bit_nxt = '0;
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      acc_nxt = {acc_r[VALUE_BITS-2:0], trial_ge};
      rem_nxt = trial_ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      bit_nxt = bit_r + BW'(1);
    end else if (cmd.store) begin
      cnt_nxt = cnt_r + CW'(1);
      bit_nxt = '0;
      rem_nxt = '0;
    end else if (cmd.load) begin
      cnt_nxt = cnt_m1;
    end else if (cmd.clear) begin
      acc_nxt   = '0;
      phase_nxt = PH_SPACE;
      neg_nxt   = 1'b0;
      hex_nxt   = HEX_NONE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      hex_r   <= HEX_NONE;
      cnt_r   <= '0;
      bit_r   <= '0;
    end else begin
      acc_r   <= acc_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      hex_r   <= hex_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // remainder register
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  // digit store write, least significant digit first
  always_ff @(posedge clk) begin
    if (cmd.store) store_mem[cnt_r[AW-1:0]] <= rem_r;
  end

  // digit store read, most significant remaining digit
  always_ff @(posedge clk) begin
    if (cmd.read) rdata_r <= store_mem[cnt_m1[AW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      digit_r <= digit_char(rdata_r);
      last_r  <= (cnt_r == CW'(1));
    end
  end

  assign out_digit_code = digit_r;
  assign out_last_digit = last_r;

  // status to controller
  assign status.acc_zero   = (acc_r == '0);
  assign status.div_done   = (bit_r == BW'(VALUE_BITS - 1));
  assign status.count_full = (cnt_r == CW'(MAX_DIGITS - 1));
  assign status.count_zero = (cnt_r == '0);

endmodule

// ===== src/radix_string_converter_core.sv =====
// Radix string converter: characters of a number string in the source base arrive one per
// transfer with the final one marked by in_is_last. Parsing works like strtol (leading
// blanks, optional sign, optional 0x in base 16, stop at the first non-digit) and the
// magnitude saturates at 2^VALUE_BITS-1. After the marked character the value comes out
// in the destination base, most significant digit first, one ASCII digit per transfer with
// out_last_digit on the final one; zero or negative values give a single '0'. Only the
// least significant MAX_DIGITS digits are emitted. After the marked character is taken,
// the conversion is set up, then each output digit is made in the one-bit-per-cycle
// divider (a zero value skips division), then each output digit is read, loaded and
// offered, waiting out any output stall; the input stalls during this whole conversion.
// Bases outside 2..36 act as the nearest limit.
module radix_string_converter_core
  import rsc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input characters
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_last,
  // output digits
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_digit_code,
  output logic        out_last_digit,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0]  src_base_r;
  logic [5:0]  dst_base_r;
  logic        cfg_wr;
  cfg_reg_t    cfg_sel;
  rsc_cmd_t    cmd;
  rsc_status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r <= 6'd10;
      dst_base_r <= 6'd10;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SRC_BASE: src_base_r <= pwdata[5:0];
        REG_DST_BASE: dst_base_r <= pwdata[5:0];
        default:      src_base_r <= src_base_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_sel)
      REG_SRC_BASE: prdata = {26'b0, src_base_r};
      REG_DST_BASE: prdata = {26'b0, dst_base_r};
      default:      prdata = '0;
    endcase
  end

  rsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  rsc_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .src_base       (clamp_base(src_base_r)),
    .dst_base       (clamp_base(dst_base_r)),
    .in_char_code   (in_char_code),
    .cmd            (cmd),
    .status         (status),
    .out_digit_code (out_digit_code),
    .out_last_digit (out_last_digit)
  );

  // the marked character starts a conversion, so the input stalls next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last |=> in_stall)
    else $error("input taken during conversion");

  // after the final digit transfer the block takes characters again
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_digit |=> !in_stall)
    else $error("block not idle after final digit");

  // no digit is offered while characters are being taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("digit offered while parsing");

  // emitted codes are 0-9 or A-Z
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_code >= 7'h30 && out_digit_code <= 7'h39) ||
                  (out_digit_code >= 7'h41 && out_digit_code <= 7'h5A))
    else $error("digit code out of range");

endmodule

// ===== tb/rsc_digit_checker.sv =====
module rsc_digit_checker
  import rsc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  out_digit_code,
  input  logic        out_last_digit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          failures,
  output int          digits_left
);

  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } digit_t;

  // digits still owed by the block, oldest first
  digit_t digits_due[$];

  // shadow of the registers and of the string parser
  logic [5:0]      src_base;
  logic [5:0]      dst_base;
  longint unsigned magnitude;
  parse_phase_t    phase;
  logic            minus;
  hex_prefix_t     prefix;

  // radix actually used for a register value
  function automatic int unsigned radix_of(input logic [5:0] r);
    int unsigned v;
    v = int'(r);
    v = (v < 2) ? 2 : v;
    v = (v > 36) ? 36 : v;
    return v;
  endfunction

  // numeric weight of a character, 99 when it is no digit at all
  function automatic int unsigned char_weight(input logic [7:0] c);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) return int'(c - CHAR_ZERO);
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) return int'(c - CHAR_UPPER_A) + 10;
    if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) return int'(c - CHAR_LOWER_A) + 10;
    return 99;
  endfunction

  function automatic logic [6:0] ascii_of(input logic [5:0] r);
    if (r < 6'd10) return 7'(r) + CHAR_ZERO[6:0];
    return 7'(r) - 7'd10 + CHAR_UPPER_A[6:0];
  endfunction

  function automatic void clear_string();
    magnitude = 0;
    phase     = PH_SPACE;
    minus     = 1'b0;
    prefix    = HEX_NONE;
  endfunction

  // strtol-like parse of one character
  function automatic void absorb_char(input logic [7:0] c);
    int unsigned b;
    int unsigned d;
    b = radix_of(src_base);
    d = char_weight(c);
    if (phase == PH_STOP) return;
    if (phase == PH_SPACE) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        minus = (c == CHAR_MINUS);
        phase = PH_SIGN;
        return;
      end
    end
    // 0x after a lone leading zero in base 16
    if (phase == PH_DIGITS && prefix == HEX_ZERO &&
        (c == CHAR_LOWER_X || c == CHAR_UPPER_X)) begin
      prefix = HEX_AFTER_X;
      return;
    end
    if (d >= b) begin
      phase = PH_STOP;
      return;
    end
    if (phase != PH_DIGITS) begin
      prefix = (b == 16 && d == 0) ? HEX_ZERO : HEX_NONE;
    end else begin
      prefix = HEX_NONE;
    end
    phase = PH_DIGITS;
    // saturate the magnitude
    if (magnitude > (VALUE_MAX - longint'(d)) / longint'(b)) begin
      magnitude = VALUE_MAX;
    end else begin
      magnitude = magnitude * b + d;
    end
  endfunction

  // digits of the finished value, most significant first
  function automatic void emit_digits();
    longint unsigned v;
    int unsigned     b;
    int              n;
    logic [5:0]      rems[MAX_DIGITS];
    v = minus ? 64'd0 : magnitude;
    b = radix_of(dst_base);
    n = 0;
    if (v == 0) begin
      rems[0] = '0;
      n = 1;
    end
    while (v != 0 && n < MAX_DIGITS) begin
      rems[n] = 6'(v % b);
      n++;
      v = v / b;
    end
    for (int i = n - 1; i >= 0; i--) begin
      digits_due.push_back(digit_t'{code: ascii_of(rems[i]), last: (i == 0)});
    end
  endfunction

  function automatic void report_fail(input string field, input int want, input int got);
    failures++;
    $error("%s expected %0d got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin
    digit_t head;
    if (!rst_n) begin
      src_base = 6'd10;
      dst_base = 6'd10;
      failures = 0;
      digits_due.delete();
      clear_string();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[2]))
          REG_SRC_BASE: src_base = pwdata[5:0];
          REG_DST_BASE: dst_base = pwdata[5:0];
          default: ;
        endcase
      end
      // character transfer
      if (in_valid && !in_stall) begin
        absorb_char(in_char_code);
        if (in_is_last) begin
          emit_digits();
          clear_string();
        end
      end
      // digit transfer
      if (out_valid && !out_stall) begin
        if (digits_due.size() == 0) begin
          report_fail("digit_code (none pending)", -1, int'(out_digit_code));
        end else begin
          head = digits_due.pop_front();
          if (head.code != out_digit_code) begin
            report_fail("digit_code", int'(head.code), int'(out_digit_code));
          end
          if (head.last != out_last_digit) begin
            report_fail("last_digit", int'(head.last), int'(out_last_digit));
          end
        end
      end
    end
    digits_left = digits_due.size();
  end

endmodule

// ===== tb/tb_radix_string_converter_core.sv =====
module tb_radix_string_converter_core
  import rsc_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_digit_code;
  logic        out_last_digit;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          failures;
  int          digits_left;
  logic        quiet_tail = 1'b0;
  logic [5:0]  src_setting = 6'd10;
  int unsigned burst_left = 0;
  int unsigned random_items = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  radix_string_converter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_code (out_digit_code),
    .out_last_digit (out_last_digit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  rsc_digit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_code (out_digit_code),
    .out_last_digit (out_last_digit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .failures       (failures),
    .digits_left    (digits_left)
  );

  // output stall in bursts, free runs in between
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_stall <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 8);
    end else begin
      out_stall  <= 1'b0;
      burst_left <= $urandom_range(0, 29);
    end
  end

  // one character transfer, with an optional idle gap first
  task automatic send_char(input logic [7:0] c, input logic last);
    logic taken;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_is_last   <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // wait until every owed digit has come out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (digits_left != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [5:0] val);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // upper bits are junk the block must drop
    pwdata  <= {26'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
  endtask

  task automatic set_bases(input logic [5:0] src, input logic [5:0] dst);
    drain();
    write_reg(REG_SRC_BASE, src);
    write_reg(REG_DST_BASE, dst);
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    src_setting = src;
  endtask

  // bases weighted toward the limits and the out of range codes
  function automatic logic [5:0] pick_base();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd36;
      4: return 6'd37;
      5: return 6'd63;
      6: return 6'd16;
      default: return 6'($urandom_range(2, 36));
    endcase
  endfunction

  function automatic logic [7:0] digit_text(input int unsigned v);
    if (v < 10) return CHAR_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(v - 10);
  endfunction

  // mostly well-formed numbers, some raw byte noise
  task automatic send_random_string();
    logic [7:0]  text[$];
    int unsigned b;
    int unsigned n;
    int unsigned k;
    b = (src_setting < 2) ? 2 : (src_setting > 36) ? 36 : int'(src_setting);
    if ($urandom_range(0, 99) < 85) begin
      repeat ($urandom_range(0, 2)) begin
        k = $urandom_range(8, 13);
        text.push_back(k == 8 ? CHAR_SPACE : 8'(k));
      end
      k = $urandom_range(0, 3);
      if (k == 0) begin
        text.push_back(CHAR_PLUS);
      end else if (k == 1) begin
        text.push_back(CHAR_MINUS);
      end
      if (b == 16 && $urandom_range(0, 2) == 0) begin
        text.push_back(CHAR_ZERO);
        text.push_back($urandom_range(0, 1) ? CHAR_UPPER_X : CHAR_LOWER_X);
      end
      // now and then long enough to saturate
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 66) : $urandom_range(1, 6);
      repeat (n) text.push_back(digit_text($urandom_range(0, b - 1)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) text.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(0, 255)));
    end
    random_items += text.size();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bases: blanks and sign, sign alone, stop then ignored, byte extremes
    send_text("\t-4");
    send_text("+");
    send_text("7a9");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    // hex prefix with and without a digit behind it
    set_bases(6'd16, 6'd2);
    send_text("0xg");
    send_text("0X1");

    // saturation, longest digit string
    set_bases(6'd36, 6'd2);
    send_text("zzzzzzzzzzzzz");

    // out of range register values
    set_bases(6'd0, 6'd63);
    send_text("1");
    set_bases(6'd37, 6'd1);
    send_text("z");

    // random strings, no idling near the end
    while (random_items < 70) begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        set_bases(pick_base(), pick_base());
      end
      if (random_items >= 55) begin
        quiet_tail <= 1'b1;
      end
      send_random_string();
    end

    drain();
    @(negedge clk);
    if (failures == 0 && digits_left == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
